### sv/wheel_pulse_speedometer_unit_assert.svh
// ----------------------------------------------------------------------------
// Wheel pulse speedometer assertion macros
// Shared concurrent assertion forms for the speedometer RTL.
// ----------------------------------------------------------------------------
`ifndef WHEEL_PULSE_SPEEDOMETER_UNIT_ASSERT_SVH
`define WHEEL_PULSE_SPEEDOMETER_UNIT_ASSERT_SVH

// same-cycle implication
`define WPSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WPSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/wpsu_pkg.sv
// ----------------------------------------------------------------------------
// Wheel pulse speedometer package
// Field widths, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package wpsu_pkg;

    localparam int FIELD_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_CM       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_DIVISOR = 2'd2;

    localparam logic [FIELD_W-1:0] WHEEL_CM_RESET       = 16'd686;
    localparam logic [FIELD_W-1:0] DEBOUNCE_TICKS_RESET = 16'd2755;
    localparam logic [DIV_W-1:0]   PERIOD_DIVISOR_RESET = 8'd12;

    localparam logic [FIELD_W-1:0] SPEED_SATURATED = 16'hFFFF;

    typedef logic [FIELD_W-1:0] word_t;

    typedef struct packed {
        word_t pulse_count;
        word_t last_capture;
        word_t prev_capture;
        logic  overflowed;
    } result_fields_t;

endpackage

### sv/wpsu_if.sv
// ----------------------------------------------------------------------------
// Wheel pulse speedometer channels
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface wpsu_tick_if;
    logic valid;
    logic ready;
    logic pulse;

    modport source (output valid, output pulse, input ready);
    modport sink   (input valid, input pulse, output ready);
endinterface

interface wpsu_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] speed;
    logic [15:0] pulse_count;
    logic [15:0] last_capture;
    logic [15:0] prev_capture;
    logic        overflowed;

    modport source (output valid, output speed, output pulse_count, output last_capture,
                    output prev_capture, output overflowed, input ready);
    modport sink   (input valid, input speed, input pulse_count, input last_capture,
                    input prev_capture, input overflowed, output ready);
endinterface

interface wpsu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/wpsu_queue.sv
// ----------------------------------------------------------------------------
// Wheel pulse speedometer queue
// Small FIFO between the tick front end and the speed back end.
// ----------------------------------------------------------------------------
module wpsu_queue #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/wpsu_front.sv
// ----------------------------------------------------------------------------
// Wheel pulse speedometer front end
// Tick counter, debounced edge capture, wrap clearing and queue push.
// ----------------------------------------------------------------------------
module wpsu_front
    import wpsu_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_pulse,
    output logic           in_ready,
    input  word_t          debounce_ticks,
    input  logic           q_full,
    output logic           push,
    output result_fields_t push_fields,
    output logic [CW-1:0]  push_period
);

    localparam int CMP_W = (CW > FIELD_W) ? CW : FIELD_W;

    logic [CW-1:0]      tick_reg;
    logic [CW-1:0]      tick_next;
    logic [CW-1:0]      last_reg;
    logic [CW-1:0]      last_next;
    logic [CW-1:0]      prev_reg;
    logic [CW-1:0]      prev_next;
    word_t              count_reg;
    word_t              count_next;
    logic [CW-1:0]      elapsed;
    logic               wrapped;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        elapsed    = tick_reg - last_reg;
        last_next  = last_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        tick_next  = tick_reg;
        wrapped    = 1'b0;
        if (push)
        begin
            if (in_pulse && (CMP_W'(elapsed) > CMP_W'(debounce_ticks)))
            begin
                prev_next  = last_reg;
                last_next  = tick_reg;
                count_next = count_reg + 1'b1;
            end
            tick_next = tick_reg + 1'b1;
            wrapped   = (tick_reg == '1);
            if (wrapped)
            begin
                last_next  = '0;
                prev_next  = '0;
                count_next = '0;
            end
        end
        push_fields.pulse_count  = count_next;
        push_fields.last_capture = FIELD_W'(last_next);
        push_fields.prev_capture = FIELD_W'(prev_next);
        push_fields.overflowed   = wrapped;
        push_period              = last_next - prev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            last_reg  <= '0;
            prev_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            tick_reg  <= tick_next;
            last_reg  <= last_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

### sv/wpsu_divider.sv
// ----------------------------------------------------------------------------
// Wheel pulse speedometer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpsu_divider #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] dvs_reg;
    logic [WIDTH-1:0] dvs_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             ge;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[WIDTH-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

### sv/wpsu_back.sv
// ----------------------------------------------------------------------------
// Wheel pulse speedometer back end
// Speed from the queued period, cached per period, and the result register.
// ----------------------------------------------------------------------------
module wpsu_back
    import wpsu_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  result_fields_t head_fields,
    input  logic [CW-1:0]  head_period,
    output logic           pop,
    input  word_t          wheel_cm,
    input  logic [DIV_W-1:0] period_divisor,
    input  logic           cfg_write,
    output logic           out_valid,
    input  logic           out_ready,
    output word_t          out_speed,
    output result_fields_t out_fields
);

    `include "wheel_pulse_speedometer_unit_assert.svh"

    localparam int DW = (CW > FIELD_W) ? CW : FIELD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV1 = 2'd1;
    localparam logic [1:0] ST_DIV2 = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             cache_valid_reg;
    logic             cache_valid_next;
    logic [CW-1:0]    cache_period_reg;
    logic [CW-1:0]    cache_period_next;
    word_t            cache_speed_reg;
    word_t            cache_speed_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    word_t            out_speed_reg;
    word_t            out_speed_next;
    result_fields_t   out_fields_reg;
    result_fields_t   out_fields_next;
    logic             div_start;
    logic [DW-1:0]    div_dividend;
    logic [DW-1:0]    div_divisor;
    logic             div_done;
    logic [DW-1:0]    div_quotient;
    logic [CW-1:0]    scaled;
    logic [DIV_W-1:0] divisor_eff;
    logic             out_free;
    logic             hit;
    logic             zero_period;

    wpsu_divider #(.WIDTH(DW)) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid  = out_valid_reg;
    assign out_speed  = out_speed_reg;
    assign out_fields = out_fields_reg;

    always_comb
    begin
        divisor_eff       = (period_divisor == '0) ? DIV_W'(1) : period_divisor;
        out_free          = !out_valid_reg || out_ready;
        zero_period       = (head_period == '0);
        hit               = cache_valid_reg && (cache_period_reg == head_period);
        scaled            = div_quotient[CW-1:0];
        state_next        = state_reg;
        cache_valid_next  = cache_valid_reg;
        cache_period_next = cache_period_reg;
        cache_speed_next  = cache_speed_reg;
        out_speed_next    = out_speed_reg;
        out_fields_next   = out_fields_reg;
        div_start         = 1'b0;
        div_dividend      = DW'(head_period);
        div_divisor       = DW'(divisor_eff);
        pop               = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (zero_period || hit)
                    begin
                        pop = out_free;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV1;
                    end
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    if (scaled == '0)
                    begin
                        cache_valid_next  = 1'b1;
                        cache_period_next = head_period;
                        cache_speed_next  = SPEED_SATURATED;
                        state_next        = ST_IDLE;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = DW'(wheel_cm);
                        div_divisor  = DW'(scaled);
                        state_next   = ST_DIV2;
                    end
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    cache_valid_next  = 1'b1;
                    cache_period_next = head_period;
                    cache_speed_next  = div_quotient[FIELD_W-1:0];
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_write)
        begin
            cache_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_speed_next  = zero_period ? '0 : cache_speed_reg;
            out_fields_next = head_fields;
            out_valid_next  = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        cache_period_reg <= cache_period_next;
        cache_speed_reg  <= cache_speed_next;
        out_speed_reg    <= out_speed_next;
        out_fields_reg   <= out_fields_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cache_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cache_valid_reg <= cache_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    `WPSU_ASSERT_IMPLIES(a_pop_slot_free, clk, rst_n, pop, !out_valid_reg || out_ready, "pop into busy result register")
    `WPSU_ASSERT_IMPLIES(a_divide_has_head, clk, rst_n, state_reg != ST_IDLE, head_valid, "divide without queued tick")
    `WPSU_ASSERT_NEXT(a_pop_loads_result, clk, rst_n, pop, out_valid_reg, "popped tick not presented")

endmodule

### sv/wheel_pulse_speedometer_unit.sv
// ----------------------------------------------------------------------------
// Wheel pulse speedometer
// Pulse-period tachometer: debounced wheel edge capture per timer tick and
// wheel speed from the captured period.
//
//   channel  role    handshake      payload
//   tick     sink    valid/ready    pulse
//   result   source  valid/ready    speed, pulse_count, last/prev_capture,
//                                   overflowed
//   cfg      sink    valid/ready    index, data (ready always high)
//
// A tick is accepted every cycle while the queue has room; one result per tick.
// Cached-period results leave at one per cycle while result.ready is high.
// A new period is divided in the shared divider and its speed cached.
// QUEUE_DEPTH ticks are absorbed meanwhile; then tick.ready drops.
// Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wheel_pulse_speedometer_unit
    import wpsu_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    wpsu_tick_if.sink     tick,
    wpsu_result_if.source result,
    wpsu_cfg_if.sink      cfg
);

    localparam int Q_W = $bits(result_fields_t) + COUNTER_WIDTH;

    word_t              wheel_cm_reg;
    word_t              wheel_cm_next;
    word_t              debounce_reg;
    word_t              debounce_next;
    logic [DIV_W-1:0]   divisor_reg;
    logic [DIV_W-1:0]   divisor_next;
    logic               cfg_write;
    logic               q_full;
    logic               q_push;
    result_fields_t     push_fields;
    logic [COUNTER_WIDTH-1:0] push_period;
    logic               q_pop;
    logic               q_head_valid;
    logic [Q_W-1:0]     q_head_data;
    result_fields_t     head_fields;
    logic [COUNTER_WIDTH-1:0] head_period;
    result_fields_t     out_fields;
    word_t              out_speed;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    always_comb
    begin
        wheel_cm_next = wheel_cm_reg;
        debounce_next = debounce_reg;
        divisor_next  = divisor_reg;
        if (cfg_write)
        begin
            case (cfg.index)
                REG_WHEEL_CM:       wheel_cm_next = cfg.data;
                REG_DEBOUNCE_TICKS: debounce_next = cfg.data;
                REG_PERIOD_DIVISOR: divisor_next  = cfg.data[DIV_W-1:0];
                default:            wheel_cm_next = wheel_cm_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_cm_reg <= WHEEL_CM_RESET;
            debounce_reg <= DEBOUNCE_TICKS_RESET;
            divisor_reg  <= PERIOD_DIVISOR_RESET;
        end
        else
        begin
            wheel_cm_reg <= wheel_cm_next;
            debounce_reg <= debounce_next;
            divisor_reg  <= divisor_next;
        end
    end

    wpsu_front #(.CW(COUNTER_WIDTH)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (tick.valid),
        .in_pulse       (tick.pulse),
        .in_ready       (tick.ready),
        .debounce_ticks (debounce_reg),
        .q_full         (q_full),
        .push           (q_push),
        .push_fields    (push_fields),
        .push_period    (push_period)
    );

    wpsu_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({push_period, push_fields}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    assign head_fields = q_head_data[$bits(result_fields_t)-1:0];
    assign head_period = q_head_data[Q_W-1:$bits(result_fields_t)];

    wpsu_back #(.CW(COUNTER_WIDTH)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (q_head_valid),
        .head_fields    (head_fields),
        .head_period    (head_period),
        .pop            (q_pop),
        .wheel_cm       (wheel_cm_reg),
        .period_divisor (divisor_reg),
        .cfg_write      (cfg_write),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_speed      (out_speed),
        .out_fields     (out_fields)
    );

    assign result.speed        = out_speed;
    assign result.pulse_count  = out_fields.pulse_count;
    assign result.last_capture = out_fields.last_capture;
    assign result.prev_capture = out_fields.prev_capture;
    assign result.overflowed   = out_fields.overflowed;

endmodule
